[hdl/fnab_pkg.sv]
// Shared widths, defaults and register indexes for the four-neighbor average blur.
package fnab_pkg;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int MAX_ROWS_DEF   = 4096;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int PIX_W      = 16;
  localparam int ROW_CNT_W  = 13;
  localparam int COL_CNT_W  = 11;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;

  localparam int MIN_DIM = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 1'b1;

endpackage

[hdl/four_neighbor_average_blur.sv]
// Top level of the four-neighbor average blur over a raster-order pixel stream.
//
// Input stream (in_*): one grayscale pixel per transfer, raster order, row after row.
// Output stream (out_*): one blurred value per interior pixel; out_tlast marks the
// last interior result of the frame. Border pixels give no output transfer.
// Configuration: cfg_we with cfg_index selects row count (0) or column count (1);
// sizes are clamped to 3..MAX_ROWS and 3..MAX_COLS. Any write restarts the frame.
// Write configuration only while the block is idle.
// Throughput: one pixel per cycle unless the output stalls. The two previous lines sit
// in one line memory of DEPTH = 2**(CW+1) entries, read at two addresses and written
// at one per accepted pixel; each read is fetched one pixel ahead of its use.
// Output: a result shows on out_* in the cycle after the transfer of the pixel
// directly below the center.
// Reset (rst_n low, synchronous): the frame position returns to the first pixel,
// sizes return to 3 by 3 and the output register empties. The line memory is not
// cleared; only rows already received in the current frame are read.
// Receiver stall: the output register holds its result; pixels that produce no
// result are still taken, and a pixel that produces one waits until the register
// is free or is drained in the same cycle.
module four_neighbor_average_blur #(
  parameter int MAX_COLS   = fnab_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS   = fnab_pkg::MAX_ROWS_DEF,
  parameter int PIXEL_BITS = fnab_pkg::PIXEL_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fnab_pkg::PIX_W-1:0]       in_tdata,   // [15:0] pixel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [fnab_pkg::PIX_W-1:0]       out_tdata,  // [15:0] blurred
  output logic                             out_tlast,
  input  logic                             cfg_we,
  input  logic [fnab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fnab_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AW    = CW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam int SUM_W = PIXEL_BITS + 2;

  logic [RW-1:0]         row_r, row_nxt;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         last_row_r;
  logic [CW-1:0]         last_col_r;
  logic [RW-1:0]         cfg_last_row;
  logic [CW-1:0]         cfg_last_col;

  logic [PIXEL_BITS-1:0] line_mem [DEPTH];
  logic [PIXEL_BITS-1:0] rd_x_r, rd_right_r, right_d1_r, left_r;
  logic [AW-1:0]         wr_addr, x_addr, right_addr;

  logic                  in_acc, produce;
  logic [PIXEL_BITS-1:0] px;
  logic [SUM_W-1:0]      sum;

  logic                  out_valid_r;
  logic [fnab_pkg::PIX_W-1:0] out_data_r;
  logic                  out_last_r;

  always_comb begin
    int rows, cols;
    rows = int'(cfg_data[fnab_pkg::ROW_CNT_W-1:0]);
    cols = int'(cfg_data[fnab_pkg::COL_CNT_W-1:0]);
    if (rows < fnab_pkg::MIN_DIM) begin
      rows = fnab_pkg::MIN_DIM;
    end else if (rows > MAX_ROWS) begin
      rows = MAX_ROWS;
    end
    if (cols < fnab_pkg::MIN_DIM) begin
      cols = fnab_pkg::MIN_DIM;
    end else if (cols > MAX_COLS) begin
      cols = MAX_COLS;
    end
    cfg_last_row = RW'(rows - 1);
    cfg_last_col = CW'(cols - 1);
  end

  assign produce   = (row_r >= RW'(2)) && (col_r != '0) && (col_r < last_col_r);
  assign in_tready = !out_valid_r || out_tready || !produce;
  assign in_acc    = in_tvalid && in_tready;
  assign px        = in_tdata[PIXEL_BITS-1:0];

  always_comb begin
    if (col_r == last_col_r) begin
      col_nxt = '0;
      row_nxt = (row_r == last_row_r) ? '0 : RW'(row_r + RW'(1));
    end else begin
      col_nxt = CW'(col_r + CW'(1));
      row_nxt = row_r;
    end
  end

  // column zero gives no result, so its upper fetch brings the previous row's first pixel
  assign wr_addr    = {row_r[0], col_r};
  assign x_addr     = (col_nxt == '0) ? {~row_nxt[0], CW'(0)} : {row_nxt[0], col_nxt};
  assign right_addr = {~row_nxt[0], CW'(col_nxt + CW'(1))};

  assign sum = SUM_W'(rd_x_r) + SUM_W'(left_r) + SUM_W'(rd_right_r) + SUM_W'(px);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_mem[wr_addr] <= px;
      rd_x_r            <= line_mem[x_addr];
      rd_right_r        <= line_mem[right_addr];
      right_d1_r        <= rd_right_r;
      left_r            <= (col_r == '0) ? rd_x_r : right_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      last_row_r <= RW'(fnab_pkg::MIN_DIM - 1);
      last_col_r <= CW'(fnab_pkg::MIN_DIM - 1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fnab_pkg::CFG_ROW_COUNT: last_row_r <= cfg_last_row;
        fnab_pkg::CFG_COL_COUNT: last_col_r <= cfg_last_col;
        default: ;
      endcase
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && produce) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && produce) begin
      out_data_r <= fnab_pkg::PIX_W'(sum[SUM_W-1:2]);
      out_last_r <= (row_r == last_row_r) && (col_r == CW'(last_col_r - CW'(1)));
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[hdl/fnab_checker.sv]
// Port-level checks for the four-neighbor average blur, bound to its top level.
module fnab_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [fnab_pkg::PIX_W-1:0]       out_tdata,
  input logic                             out_tlast
);

  logic in_xfer, out_xfer;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_result_needs_input: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid ##1 out_tvalid |-> $past(in_xfer))
    else $error("result without input transfer");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !in_xfer |=> !out_tvalid)
    else $error("result repeated after transfer");

endmodule

bind four_neighbor_average_blur fnab_checker u_fnab_checker (.*);

[tb/tb_four_neighbor_average_blur.sv]
// Self-checking testbench for the four-neighbor average blur with directed and random frames.
module tb_four_neighbor_average_blur;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT   = 1000;
  localparam int RANDOM_ITEMS = 600;

  typedef struct packed {
    logic [fnab_pkg::PIX_W-1:0] blurred;
    logic                       frame_end;
  } blur_t;

  typedef struct packed {
    logic [fnab_pkg::PIX_W-1:0] pix;
    logic                       typed;
    logic [fnab_pkg::PIX_W-1:0] exp_blur;
    logic                       exp_last;
  } stim_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [fnab_pkg::PIX_W-1:0]      in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [fnab_pkg::PIX_W-1:0]      out_tdata;
  logic                            out_tlast;
  logic                            cfg_we;
  logic [fnab_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [fnab_pkg::CFG_DATA_W-1:0] cfg_data;

  bit [fnab_pkg::PIX_W-1:0]       line_mem [0:2*fnab_pkg::MAX_COLS_DEF-1];
  int unsigned                    cur_row;
  int unsigned                    cur_col;
  logic [fnab_pkg::ROW_CNT_W-1:0] rows_reg;
  logic [fnab_pkg::COL_CNT_W-1:0] cols_reg;

  blur_t       pending_blur [$];
  int unsigned errors;
  int unsigned in_sent;
  int unsigned out_seen;
  bit          in_calm;
  bit          out_calm;
  int unsigned idle_cycles;
  stim_row_t   directed_rows [0:25];

  four_neighbor_average_blur dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned frame_rows();
    int unsigned n;
    n = rows_reg;
    if (n < fnab_pkg::MIN_DIM) n = fnab_pkg::MIN_DIM;
    if (n > fnab_pkg::MAX_ROWS_DEF) n = fnab_pkg::MAX_ROWS_DEF;
    return n;
  endfunction

  function automatic int unsigned frame_cols();
    int unsigned n;
    n = cols_reg;
    if (n < fnab_pkg::MIN_DIM) n = fnab_pkg::MIN_DIM;
    if (n > fnab_pkg::MAX_COLS_DEF) n = fnab_pkg::MAX_COLS_DEF;
    return n;
  endfunction

  function automatic int unsigned line_addr(int unsigned r, int unsigned c);
    return ((r & 1) * fnab_pkg::MAX_COLS_DEF + c) % (2 * fnab_pkg::MAX_COLS_DEF);
  endfunction

  // Advance the frame position by one pixel; return 1 when a blurred value is due.
  function automatic bit compute_blur(input logic [fnab_pkg::PIX_W-1:0] pix,
                                      output blur_t res);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    int unsigned sum;
    bit          hit;
    rows = frame_rows();
    cols = frame_cols();
    r = cur_row;
    c = cur_col;
    hit = 1'b0;
    res = '0;
    if (r >= rows) r = 0;
    if (c >= cols) c = 0;
    if (r >= 2 && c >= 1 && c + 1 < cols) begin
      sum = 32'(line_mem[line_addr(r, c)]) + 32'(line_mem[line_addr(r + 1, c - 1)])
          + 32'(line_mem[line_addr(r + 1, c + 1)]) + 32'(pix);
      res.blurred   = fnab_pkg::PIX_W'(sum >> 2);
      res.frame_end = (r + 1 == rows) && (c + 2 == cols);
      hit = 1'b1;
    end
    line_mem[line_addr(r, c)] = pix;
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    cur_row = r;
    cur_col = c;
    return hit;
  endfunction

  function automatic logic [fnab_pkg::PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return fnab_pkg::PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_pixel(input logic [fnab_pkg::PIX_W-1:0] pix, input bit typed,
                            input blur_t typed_res);
    int unsigned gap;
    bit          hit;
    blur_t       res;
    if (in_sent % 40 == 0) in_calm = ($urandom_range(0, 3) == 0);
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    in_sent++;
    hit = compute_blur(pix, res);
    if (typed) begin
      hit = 1'b1;
      res = typed_res;
    end
    if (hit) begin
      pending_blur.push_back(res);
    end
  endtask

  // Hold the input until every expected transfer has come out, then let the pipe settle.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame(input bit do_row, input logic [fnab_pkg::CFG_DATA_W-1:0] row_data,
                           input bit do_col, input logic [fnab_pkg::CFG_DATA_W-1:0] col_data);
    if (do_row) begin
      cfg_we    <= 1'b1;
      cfg_index <= fnab_pkg::CFG_ROW_COUNT;
      cfg_data  <= row_data;
      @(posedge clk);
      rows_reg = row_data[fnab_pkg::ROW_CNT_W-1:0];
      cur_row  = 0;
      cur_col  = 0;
    end
    if (do_col) begin
      cfg_we    <= 1'b1;
      cfg_index <= fnab_pkg::CFG_COL_COUNT;
      cfg_data  <= col_data;
      @(posedge clk);
      cols_reg = col_data[fnab_pkg::COL_CNT_W-1:0];
      cur_row  = 0;
      cur_col  = 0;
    end
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("four_neighbor_average_blur: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned gap;
    blur_t       want;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_seen % 40 == 0) out_calm = ($urandom_range(0, 3) == 0);
      gap = out_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      out_seen++;
      if (pending_blur.size() == 0) begin
        $display("%0t: unexpected transfer blurred %h last %b", $time, out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_blur.pop_front();
        if (out_tdata !== want.blurred) begin
          $display("%0t: blurred expected %h got %h", $time, want.blurred, out_tdata);
          errors++;
        end
        if (out_tlast !== want.frame_end) begin
          $display("%0t: frame end expected %b got %b", $time, want.frame_end, out_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned wr;
    int unsigned len;
    int unsigned count;
    int unsigned rand_items;
    logic [fnab_pkg::CFG_DATA_W-1:0] rd;
    logic [fnab_pkg::CFG_DATA_W-1:0] cd;

    directed_rows = '{
      '{16'hFFFF, 1'b0, 16'h0000, 1'b0}, '{16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 16'h0000, 1'b0}, '{16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 16'h0000, 1'b0}, '{16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 16'h0000, 1'b0}, '{16'hFFFF, 1'b1, 16'hFFFF, 1'b1},
      '{16'hFFFF, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 1'b0, 16'h0000, 1'b0}, '{16'h0000, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 1'b0, 16'h0000, 1'b0}, '{16'h0000, 1'b0, 16'h0000, 1'b0},
      '{16'hFFFF, 1'b0, 16'h0000, 1'b0}, '{16'h0000, 1'b0, 16'h0000, 1'b0},
      '{16'h0000, 1'b0, 16'h0000, 1'b0}, '{16'h0000, 1'b1, 16'h0000, 1'b1},
      '{16'h0000, 1'b0, 16'h0000, 1'b0},
      '{16'h1234, 1'b0, 16'h0000, 1'b0}, '{16'h0001, 1'b0, 16'h0000, 1'b0},
      '{16'h8000, 1'b0, 16'h0000, 1'b0}, '{16'h0001, 1'b0, 16'h0000, 1'b0},
      '{16'hAAAA, 1'b0, 16'h0000, 1'b0}, '{16'h0000, 1'b0, 16'h0000, 1'b0},
      '{16'h5555, 1'b0, 16'h0000, 1'b0}, '{16'h0001, 1'b1, 16'h0000, 1'b1}
    };

    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= fnab_pkg::CFG_ROW_COUNT;
    cfg_data  <= '0;
    errors     = 0;
    in_sent    = 0;
    out_seen   = 0;
    rows_reg   = fnab_pkg::ROW_CNT_W'(fnab_pkg::MIN_DIM);
    cols_reg   = fnab_pkg::COL_CNT_W'(fnab_pkg::MIN_DIM);
    cur_row    = 0;
    cur_col    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_pixel(directed_rows[i].pix, directed_rows[i].typed,
                 blur_t'{directed_rows[i].exp_blur, directed_rows[i].exp_last});
    end

    // wide line, then tallest frame with masked column bits
    wait_for_results();
    set_frame(1'b1, 13'd3, 1'b1, 13'd100);
    repeat (300) send_pixel(pick_pixel(), 1'b0, '0);
    wait_for_results();
    set_frame(1'b1, 13'h1FFF, 1'b1, 13'h1803);
    repeat (150) send_pixel(pick_pixel(), 1'b0, '0);
    wait_for_results();
    set_frame(1'b1, 13'd0, 1'b1, 13'd2);
    repeat (12) send_pixel(pick_pixel(), 1'b0, '0);

    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_for_results();
      sel = $urandom_range(0, 9);
      case (sel)
        0: begin
          rd = fnab_pkg::CFG_DATA_W'($urandom_range(0, 2));
          cd = fnab_pkg::CFG_DATA_W'($urandom_range(0, 2));
        end
        1: begin
          rd = fnab_pkg::CFG_DATA_W'($urandom_range(3, 6));
          cd = fnab_pkg::CFG_DATA_W'($urandom_range(3, 12))
             | (fnab_pkg::CFG_DATA_W'($urandom_range(0, 3)) << 11);
        end
        default: begin
          rd = fnab_pkg::CFG_DATA_W'($urandom_range(3, 7));
          cd = fnab_pkg::CFG_DATA_W'($urandom_range(3, 12));
        end
      endcase
      wr = $urandom_range(0, 3);
      set_frame(wr != 1, rd, wr != 0, cd);
      len = frame_rows() * frame_cols();
      if ($urandom_range(0, 5) == 0) begin
        count = $urandom_range(1, len - 1);
      end else begin
        count = len * $urandom_range(1, 2);
      end
      repeat (count) begin
        if ($urandom_range(0, 149) == 0) wait_for_results();
        send_pixel(pick_pixel(), 1'b0, '0);
        rand_items++;
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("four_neighbor_average_blur: match");
    end else begin
      $display("four_neighbor_average_blur: mismatch");
    end
    $finish;
  end

endmodule
